[sv/bdse_pkg.sv]
// Shared types, constants and helpers of the battery discharge slope estimator.
`default_nettype none

package bdse_pkg;

    // window geometry
    localparam int WINDOW = 16;
    localparam int DEPTH  = WINDOW + 1;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);

    // field and datapath widths
    localparam int NW   = 28;                 // energy sample
    localparam int EW   = 16;                 // elapsed seconds
    localparam int SYW  = NW + CW;            // sum of y
    localparam int SXYW = NW + 2 * CW;        // sum of x*y
    localparam int TW   = NW + 3 * CW;        // n*sxy and sx*sy
    localparam int SNW  = TW + 1;             // signed slope numerator
    localparam int PW   = 4 * CW;             // n^2*(n^2-1)
    localparam int DW   = NW + EW + PW;       // divider width
    localparam int QCW  = $clog2(DW + 1);     // divider step counter

    localparam int RW   = 45;                 // rate_q8
    localparam int LW   = 32;                 // time_left_seconds

    localparam logic [DW-1:0] PCT_MAX  = DW'(255);
    localparam logic [DW-1:0] RATE_MAG = DW'(1) << (RW - 1);
    localparam logic [DW-1:0] TL_MAG   = DW'(1) << (LW - 1);

    // status codes
    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_FIRST      = 3'd1,
        STS_ZERO_SLOPE = 3'd2,
        STS_ZERO_EL    = 3'd3,
        STS_ZERO_FULL  = 3'd4
    } status_t;

    // divider operand select
    typedef enum logic [1:0] {
        DSEL_PCT  = 2'd0,
        DSEL_RATE = 2'd1,
        DSEL_TL   = 2'd2
    } div_sel_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_FIT_A,
        ST_FIT_B,
        ST_FIT_C,
        ST_RATE_GO,
        ST_RATE_WAIT,
        ST_TL_GO,
        ST_TL_WAIT,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     acc;
        logic     fit_a;
        logic     fit_b;
        logic     fit_c;
        logic     div_start;
        div_sel_t div_sel;
        logic     st_pct;
        logic     st_rate;
        logic     st_tl;
        logic     out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;
        logic div_done;
    } dp_stat_t;

    // circular index wrap, sum of two indexes below DEPTH
    function automatic logic [AW-1:0] wrap_idx(input logic [CW:0] s);
        logic [CW:0] r;
        r = (s >= (CW + 1)'(DEPTH)) ? s - (CW + 1)'(DEPTH) : s;
        return r[AW-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/bdse_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module bdse_div import bdse_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quotient
);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [QCW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]  rem_reg, rem_next;
    logic [DW-1:0]  quo_reg, quo_next;
    logic [DW-1:0]  den_reg, den_next;
    logic [DW:0]    shifted;
    logic [DW:0]    diff;
    logic           ge;

    // one shift-subtract step
    always_comb begin
        shifted   = {rem_reg, quo_reg[DW-1]};
        diff      = shifted - {1'b0, den_reg};
        ge        = shifted >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == QCW'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[sv/bdse_datapath.sv]
// Sample window, window sums, slope terms, divider and result registers.
`default_nettype none

module bdse_datapath import bdse_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire dp_cmd_t              cmd,
    input  wire logic [NW-1:0]        sample_energy,
    input  wire logic [NW-1:0]        capacity_energy,
    input  wire logic [EW-1:0]        elapsed_seconds,
    output dp_stat_t                  stat,
    output logic [7:0]                charge_percent,
    output logic signed [RW-1:0]      rate_q8,
    output logic signed [LW-1:0]      time_left_seconds,
    output logic [2:0]                status
);

    // window memory
    logic [NW-1:0] mem [DEPTH];
    logic [NW-1:0] rdata_reg;
    logic [AW-1:0] wr_addr, rd_addr;

    // window bookkeeping
    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic          seen_first_reg;
    logic [CW-1:0] idx_reg;

    // captured transaction
    logic [NW-1:0] now_reg, full_reg;
    logic [EW-1:0] el_reg;
    logic          first_reg;

    // sums and fit terms
    logic [SYW-1:0]        sy_reg;
    logic [SXYW-1:0]       sxy_reg;
    logic [TW-1:0]         t1_reg, t2_reg;
    logic [2*CW-1:0]       nsq_reg;
    logic [NW+EW-1:0]      enel_reg;
    logic signed [SNW-1:0] snum_reg;
    logic [PW-1:0]         p_reg;
    logic [DW-1:0]         rnum_reg, rden_reg, tnum_reg, tden_reg;
    logic [TW-1:0]         mag;
    logic [2*CW:0]         sx_prod;
    logic [2*CW-1:0]       sx;
    logic [CW-1:0]         xval;

    // divider
    logic          div_done;
    logic [DW-1:0] div_q, div_a, div_b;

    // working and output results
    logic [7:0]           pct_reg, pct_out_reg;
    logic [RW-1:0]        rate_reg, rate_out_reg;
    logic [LW-1:0]        tl_reg, tl_out_reg;
    status_t              sts_out_reg;
    status_t              sts;
    logic                 el_zero, slope_zero;

    assign wr_addr = wrap_idx((CW + 1)'(head_reg) + (CW + 1)'(count_reg));
    assign rd_addr = wrap_idx((CW + 1)'(head_reg) + (CW + 1)'(idx_reg));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mem[wr_addr] <= sample_energy;
        end
        rdata_reg <= mem[rd_addr];
    end

    // window bookkeeping, oldest sample dropped when the window overflows
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= '0;
            count_reg      <= '0;
            seen_first_reg <= 1'b0;
        end else if (cmd.load) begin
            count_reg      <= count_reg + 1'b1;
            seen_first_reg <= 1'b1;
        end else if (cmd.out_load && count_reg > CW'(WINDOW)) begin
            head_reg  <= wrap_idx((CW + 1)'(head_reg) + (CW + 1)'(1));
            count_reg <= count_reg - 1'b1;
        end
    end

    assign xval    = idx_reg + 1'b1;
    assign sx_prod = (2 * CW + 1)'(count_reg) * (2 * CW + 1)'(count_reg + 1'b1);
    assign sx      = sx_prod[2*CW:1];
    assign mag     = snum_reg[SNW-1] ? TW'(-snum_reg) : TW'(snum_reg);

    // capture, sums and slope terms
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            now_reg   <= sample_energy;
            full_reg  <= capacity_energy;
            el_reg    <= elapsed_seconds;
            first_reg <= !seen_first_reg;
            sy_reg    <= '0;
            sxy_reg   <= '0;
            idx_reg   <= '0;
        end
        if (cmd.acc) begin
            sy_reg  <= sy_reg + SYW'(rdata_reg);
            sxy_reg <= sxy_reg + SXYW'(rdata_reg) * SXYW'(xval);
            idx_reg <= xval;
        end
        if (cmd.fit_a) begin
            t1_reg   <= TW'(count_reg) * TW'(sxy_reg);
            t2_reg   <= TW'(sx) * TW'(sy_reg);
            nsq_reg  <= (2 * CW)'(count_reg) * (2 * CW)'(count_reg);
            enel_reg <= (NW + EW)'(el_reg) * (NW + EW)'(now_reg);
        end
        if (cmd.fit_b) begin
            snum_reg <= $signed({1'b0, t1_reg}) - $signed({1'b0, t2_reg});
            p_reg    <= PW'(nsq_reg) * PW'(nsq_reg - 1'b1);
        end
        // rate = 12*mag*256/(P*el), time left = el*now*P/(12*mag)
        if (cmd.fit_c) begin
            rnum_reg <= (DW'(mag) << 11) + (DW'(mag) << 10);
            rden_reg <= DW'(p_reg) * DW'(el_reg);
            tnum_reg <= DW'(enel_reg) * DW'(p_reg);
            tden_reg <= (DW'(mag) << 3) + (DW'(mag) << 2);
        end
    end

    // divider operands
    always_comb begin
        case (cmd.div_sel)
            DSEL_RATE: begin
                div_a = rnum_reg;
                div_b = rden_reg;
            end
            DSEL_TL: begin
                div_a = tnum_reg;
                div_b = tden_reg;
            end
            default: begin
                div_a = DW'(now_reg) * DW'(7'd100);
                div_b = DW'(full_reg);
            end
        endcase
    end

    bdse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign el_zero    = el_reg == '0;
    assign slope_zero = snum_reg == '0;

    // status priority: first, zero full, zero elapsed, zero slope
    always_comb begin
        if (first_reg) begin
            sts = STS_FIRST;
        end else if (full_reg == '0) begin
            sts = STS_ZERO_FULL;
        end else if (el_zero) begin
            sts = STS_ZERO_EL;
        end else if (slope_zero) begin
            sts = STS_ZERO_SLOPE;
        end else begin
            sts = STS_OK;
        end
    end

    // saturate and sign the quotients; zero divisor falls out as all ones
    always_ff @(posedge aclk) begin
        if (cmd.st_pct) begin
            pct_reg <= (div_q > PCT_MAX) ? 8'hFF : div_q[7:0];
        end
        if (cmd.st_rate) begin
            if (first_reg || el_zero) begin
                rate_reg <= '0;
            end else if (snum_reg[SNW-1]) begin
                rate_reg <= (div_q > RATE_MAG) ? RATE_MAG[RW-1:0] : -div_q[RW-1:0];
            end else begin
                rate_reg <= (div_q > RATE_MAG - 1'b1) ? RATE_MAG[RW-1:0] - 1'b1
                                                      : div_q[RW-1:0];
            end
        end
        if (cmd.st_tl) begin
            if (first_reg || el_zero || slope_zero) begin
                tl_reg <= '0;
            end else if (snum_reg[SNW-1]) begin
                tl_reg <= (div_q >= TL_MAG) ? TL_MAG[LW-1:0] : -div_q[LW-1:0];
            end else begin
                tl_reg <= (div_q > TL_MAG - 1'b1) ? TL_MAG[LW-1:0] - 1'b1
                                                  : div_q[LW-1:0];
            end
        end
        if (cmd.out_load) begin
            pct_out_reg  <= pct_reg;
            rate_out_reg <= rate_reg;
            tl_out_reg   <= tl_reg;
            sts_out_reg  <= sts;
        end
    end

    assign stat.last         = idx_reg == count_reg - 1'b1;
    assign stat.div_done     = div_done;
    assign charge_percent    = pct_out_reg;
    assign rate_q8           = $signed(rate_out_reg);
    assign time_left_seconds = $signed(tl_out_reg);
    assign status            = sts_out_reg;

endmodule

`default_nettype wire

[sv/bdse_ctrl.sv]
// Sequencer for one sample: percent divide, window sums, fit, two divides, output.
`default_nettype none

module bdse_ctrl import bdse_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;
    logic   out_free;

    assign out_free = !mvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_PCT_GO;
            ST_PCT_GO:    state_next = ST_PCT_WAIT;
            ST_PCT_WAIT:  if (stat.div_done) state_next = ST_SUM_RD;
            ST_SUM_RD:    state_next = ST_SUM_ACC;
            ST_SUM_ACC:   state_next = stat.last ? ST_FIT_A : ST_SUM_RD;
            ST_FIT_A:     state_next = ST_FIT_B;
            ST_FIT_B:     state_next = ST_FIT_C;
            ST_FIT_C:     state_next = ST_RATE_GO;
            ST_RATE_GO:   state_next = ST_RATE_WAIT;
            ST_RATE_WAIT: if (stat.div_done) state_next = ST_TL_GO;
            ST_TL_GO:     state_next = ST_TL_WAIT;
            ST_TL_WAIT:   if (stat.div_done) state_next = ST_FINISH;
            ST_FINISH:    if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd         = '0;
        cmd.div_sel = DSEL_PCT;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_PCT_GO:   cmd.div_start = 1'b1;
            ST_PCT_WAIT: cmd.st_pct = stat.div_done;
            ST_SUM_ACC:  cmd.acc = 1'b1;
            ST_FIT_A:    cmd.fit_a = 1'b1;
            ST_FIT_B:    cmd.fit_b = 1'b1;
            ST_FIT_C:    cmd.fit_c = 1'b1;
            ST_RATE_GO: begin
                cmd.div_sel   = DSEL_RATE;
                cmd.div_start = 1'b1;
            end
            ST_RATE_WAIT: cmd.st_rate = stat.div_done;
            ST_TL_GO: begin
                cmd.div_sel   = DSEL_TL;
                cmd.div_start = 1'b1;
            end
            ST_TL_WAIT: cmd.st_tl = stat.div_done;
            ST_FINISH:  cmd.out_load = out_free;
            default: ;
        endcase
    end

    // output valid flag
    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

`ifndef NO_ASSERTIONS
    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!mvalid_reg || m_tready))
        else $error("result overwritten while stalled");

    // an accepted transaction starts the percent divide next
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_PCT_GO))
        else $error("accepted transaction did not start");

    // divider finishes only while a wait state expects it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> (state_reg == ST_PCT_WAIT || state_reg == ST_RATE_WAIT
                           || state_reg == ST_TL_WAIT))
        else $error("divider done outside a wait state");
`endif

endmodule

`default_nettype wire

[sv/battery_discharge_slope_estimator.sv]
// Top level of the battery discharge slope estimator.
//
// One input transaction carries a stored-energy sample, the full-charge
// energy and the seconds since the previous sample. Each one yields exactly
// one result transaction: charge percentage, fitted discharge rate in Q.8,
// time left in seconds and a status code.
// The slope is a least-squares fit over the newest samples (up to 17 during
// the fit, 16 kept between samples). One sample is worked at a time; the
// sequence is a percent divide, a read and an accumulate state per window
// sample for the sums, the fit states FIT_A, FIT_B and FIT_C, then two
// divides for rate and time left on the same shared divider. A new sample
// is not accepted until the sequence is through with the last one.
// s_tready is high only while the sequencer is idle. The result sits in an
// output register; a new sample is accepted while it waits, and the next
// result waits in the sequencer until m_tready frees that register.
// Reset empties the window and clears the first-sample flag; the first
// sample after reset reports the first-sample status.
`default_nettype none

module battery_discharge_slope_estimator import bdse_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // sample_energy [27:0], capacity_energy [55:28], elapsed_seconds [71:56]
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // charge_percent [7:0], rate_q8 [52:8], time_left_seconds [84:53],
    // status [87:85]
    output logic [87:0]      m_tdata
);

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic [7:0]         charge_percent;
    logic signed [44:0] rate_q8;
    logic signed [31:0] time_left_seconds;
    logic [2:0]         status;

    bdse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bdse_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sample_energy     (s_tdata[27:0]),
        .capacity_energy   (s_tdata[55:28]),
        .elapsed_seconds   (s_tdata[71:56]),
        .stat              (stat),
        .charge_percent    (charge_percent),
        .rate_q8           (rate_q8),
        .time_left_seconds (time_left_seconds),
        .status            (status)
    );

    assign m_tdata = {status, time_left_seconds, rate_q8, charge_percent};

endmodule

`default_nettype wire

[sim/bdse_checker.sv]
// Checker: watches both channels, predicts each result and compares it.
`default_nettype none

module bdse_checker import bdse_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [87:0] m_tdata,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [7:0]        pct;
        logic signed [44:0] rate;
        logic signed [31:0] tleft;
        status_t           sts;
    } fit_result_t;

    fit_result_t expected_q[$];
    logic [27:0] energy_hist[$];
    bit          have_first;

    assign pending = expected_q.size();

    // window fit and derived values for one sample
    function automatic fit_result_t fit_sample(input logic [71:0] d);
        fit_result_t r;
        logic [27:0] now, full;
        logic [15:0] el;
        longint n, sy, sxy, sx, snum, sden;
        logic [127:0] mag, q, num;
        logic [63:0] pct;
        now  = d[27:0];
        full = d[55:28];
        el   = d[71:56];
        r = '0;
        if (full == 0) r.pct = 8'd255;
        else begin
            pct = (64'd100 * now) / full;
            r.pct = (pct > 255) ? 8'd255 : pct[7:0];
        end
        if (energy_hist.size() >= DEPTH) void'(energy_hist.pop_front());
        energy_hist.push_back(now);
        if (!have_first) begin
            have_first = 1;
            r.sts = STS_FIRST;
            return r;
        end
        n = energy_hist.size();
        sy = 0;
        sxy = 0;
        foreach (energy_hist[i]) begin
            sy  += energy_hist[i];
            sxy += longint'(energy_hist[i]) * (i + 1);
        end
        sx   = n * (n + 1) / 2;
        snum = n * sxy - sx * sy;
        sden = n * n * (n * n - 1) / 12;
        mag  = 128'(snum < 0 ? -snum : snum);
        if (full == 0) r.sts = STS_ZERO_FULL;
        else if (el == 0) r.sts = STS_ZERO_EL;
        else if (snum == 0) r.sts = STS_ZERO_SLOPE;
        else r.sts = STS_OK;
        if (el != 0) begin
            q = (mag * 256) / (128'(sden) * el);
            if (snum < 0) r.rate = (q > (128'(1) << 44)) ? 45'sh1000_0000_0000 : -45'(q);
            else r.rate = (q > ((128'(1) << 44) - 1)) ? 45'h0FFF_FFFF_FFFF : 45'(q);
        end
        if (el != 0 && snum != 0) begin
            num = 128'(el) * now * 128'(sden);
            q = num / mag;
            if (snum < 0) r.tleft = (q >= 128'h8000_0000) ? 32'sh8000_0000 : -32'(q);
            else r.tleft = (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
        end
        if (energy_hist.size() > WINDOW) void'(energy_hist.pop_front());
        return r;
    endfunction

    // predict on input transactions, compare on output transactions
    always @(posedge aclk) begin
        fit_result_t exp_r, got;
        if (!aresetn) begin
            fail_count <= 0;
            expected_q.delete();
            energy_hist.delete();
            have_first = 0;
        end else begin
            if (s_tvalid && s_tready) expected_q.push_back(fit_sample(s_tdata));
            if (m_tvalid && m_tready) begin
                got = {m_tdata[7:0], m_tdata[52:8], m_tdata[84:53], m_tdata[87:85]};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.pct !== exp_r.pct || got.rate !== exp_r.rate ||
                        got.tleft !== exp_r.tleft || got.sts !== exp_r.sts) begin
                        $display("%0t: mismatch expected pct=%0d rate=%0d tl=%0d sts=%0d",
                                 $time, exp_r.pct, exp_r.rate, exp_r.tleft, exp_r.sts);
                        $display("%0t:          actual   pct=%0d rate=%0d tl=%0d sts=%0d",
                                 $time, got.pct, got.rate, got.tleft, got.sts);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

[sim/tb.sv]
// Testbench top: clock, reset, sample stimulus and the verdict.
`default_nettype none

module tb;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [87:0] m_tdata;
    int          fail_count, pending;
    longint      cycles = 0;

    localparam longint CYCLE_LIMIT = 2_000_000;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    battery_discharge_slope_estimator u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    bdse_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    // timeout guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stall pattern: phases of always-ready, random and long stalls
    always @(posedge aclk) begin
        case ((cycles / 3000) % 3)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(3) != 0);
            default: m_tready <= ($urandom_range(9) == 0);
        endcase
    end

    int burst_left = 0;

    // send one sample, bursty with random gaps; valid stays high inside a burst
    task automatic send_sample(input logic [27:0] now, input logic [27:0] full,
                               input logic [15:0] el);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(8, 1);
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(300);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {el, full, now};
        do @(posedge aclk); while (!s_tready);
    endtask

    // a plausible discharge or charge trend with noise
    logic [27:0] level;

    initial begin
        int dir, step;
        logic [27:0] full;
        logic [15:0] el;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes and every status
        send_sample(28'hFFFFFFF, 28'hFFFFFFF, 16'hFFFF);      // first sample
        send_sample(28'd0, 28'hFFFFFFF, 16'd1);               // steep fall, tiny el
        send_sample(28'hFFFFFFF, 28'd1, 16'hFFFF);            // pct saturates
        send_sample(28'd5, 28'd0, 16'd10);                    // zero full
        send_sample(28'd5, 28'd100, 16'd0);                   // zero elapsed
        send_sample(28'd0, 28'd0, 16'd0);
        for (int i = 0; i < 20; i++) send_sample(28'd1000, 28'd2000, 16'd1); // flat
        for (int i = 0; i < 18; i++)
            send_sample(28'(100000 - i * 7), 28'd200000, 16'd60);
        send_sample(28'hFFFFFFF, 28'h8000000, 16'd1);         // sharp rise

        // random: mostly trends, some noise
        level = 28'($urandom_range(28'hFFFFFFF));
        for (int i = 0; i < 800; i++) begin
            if (i % 40 == 0) begin
                dir  = $urandom_range(2);
                step = $urandom_range(1 << $urandom_range(20));
                full = 28'($urandom_range(28'hFFFFFFF));
            end
            if ($urandom_range(9) == 0) begin
                level = 28'($urandom);
                el = 16'($urandom);
                if ($urandom_range(5) == 0) full = 0;
                if ($urandom_range(5) == 0) el = 0;
            end else begin
                el = 16'($urandom_range(120, 1));
                if (dir == 0) level = 28'(level - step + $urandom_range(15));
                else if (dir == 1) level = 28'(level + step - $urandom_range(15));
            end
            send_sample(level, (full == 0 && $urandom_range(3) != 0) ? 28'($urandom) : full, el);
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);

        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
